@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg
// Types and codes shared by the line pixel generator modules.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned COLOR_W = 16;
  localparam int unsigned DIR_W   = 2;

  localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } lpg_mode_e;

  typedef struct packed {
    lpg_mode_e        mode;
    logic             x_major;
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_y;
  } lpg_ctrl_t;

  typedef struct packed {
    logic busy;
    logic pop;
    logic start;
  } lpg_status_t;

endpackage

@@ design/lpg_front.sv @@
// ----------------------------------------------------------------------------
// lpg_front
// Accepts items, classifies them and derives axis lengths and directions.
// ----------------------------------------------------------------------------
module lpg_front #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic                        fifo_full_i,
  output logic                        push_o,
  output lpg_pkg::lpg_ctrl_t          ctrl_o,
  output logic [CoordBits-1:0]        major_o,
  output logic [CoordBits-1:0]        minor_o
);
  import lpg_pkg::*;

  logic [CoordBits:0]   dx;
  logic [CoordBits:0]   dy;
  logic [CoordBits:0]   dx_abs;
  logic [CoordBits:0]   dy_abs;
  logic [CoordBits-1:0] ax;
  logic [CoordBits-1:0] ay;
  logic                 x_major;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  assign dx = {end_x_i[CoordBits-1], end_x_i} - {start_x_i[CoordBits-1], start_x_i};
  assign dy = {end_y_i[CoordBits-1], end_y_i} - {start_y_i[CoordBits-1], start_y_i};

  assign dx_abs = dx[CoordBits] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[CoordBits] ? (~dy + 1'b1) : dy;
  assign ax     = dx_abs[CoordBits-1:0];
  assign ay     = dy_abs[CoordBits-1:0];

  assign x_major = (ax >= ay);

  always_comb begin
    ctrl_o.mode    = lpg_mode_e'(mode_i);
    ctrl_o.x_major = x_major;
    if (dx == '0) begin
      ctrl_o.dir_x = DIR_ZERO;
    end else if (dx[CoordBits]) begin
      ctrl_o.dir_x = DIR_NEG;
    end else begin
      ctrl_o.dir_x = DIR_POS;
    end
    if (dy == '0) begin
      ctrl_o.dir_y = DIR_ZERO;
    end else if (dy[CoordBits]) begin
      ctrl_o.dir_y = DIR_NEG;
    end else begin
      ctrl_o.dir_y = DIR_POS;
    end
  end

  assign major_o = x_major ? ax : ay;
  assign minor_o = x_major ? ay : ax;

endmodule

@@ design/lpg_fifo.sv @@
// ----------------------------------------------------------------------------
// lpg_fifo
// Short register queue between the front and the stepper.
// ----------------------------------------------------------------------------
module lpg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rd_data_o
);
  import lpg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;

  assign full_o    = (cnt_q == (PtrW + 1)'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/lpg_back.sv @@
// ----------------------------------------------------------------------------
// lpg_back
// Bresenham stepper: holds the line state and registers one pixel per start item or advance item while drawing.
// ----------------------------------------------------------------------------
module lpg_back #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  lpg_pkg::lpg_ctrl_t            ctrl_i,
  input  logic [CoordBits-1:0]          start_x_i,
  input  logic [CoordBits-1:0]          start_y_i,
  input  logic [CoordBits-1:0]          end_x_i,
  input  logic [CoordBits-1:0]          end_y_i,
  input  logic [CoordBits-1:0]          major_i,
  input  logic [CoordBits-1:0]          minor_i,
  input  logic [lpg_pkg::COLOR_W-1:0]   color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [CoordBits-1:0]   pixel_x_o,
  output logic signed [CoordBits-1:0]   pixel_y_o,
  output logic [lpg_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          last_pixel_o,
  output lpg_pkg::lpg_status_t          status_o
);
  import lpg_pkg::*;

  localparam int unsigned ErrW = CoordBits + 2;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_e;

  state_e               state_q;
  logic [CoordBits-1:0] cur_x_q, cur_y_q;
  logic [ErrW-1:0]      err_q;
  logic [CoordBits-1:0] major_q, minor_q;
  logic [CoordBits-1:0] step_q;
  logic [DIR_W-1:0]     dir_x_q, dir_y_q;
  logic                 x_major_q;
  logic [CoordBits-1:0] tgt_x_q, tgt_y_q;
  logic [COLOR_W-1:0]   color_q;
  logic                 out_valid_q;
  logic [CoordBits-1:0] pix_x_q, pix_y_q;
  logic [COLOR_W-1:0]   pix_color_q;
  logic                 pix_last_q;

  logic                 pop;
  logic [ErrW-1:0]      err_add;
  logic                 minor_step;
  logic [ErrW-1:0]      err_d;
  logic [CoordBits-1:0] delta_x, delta_y;
  logic [CoordBits-1:0] step_x_d, step_y_d;
  logic                 interior;

  assign pop       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = pop;

  assign err_add    = err_q + {2'b00, minor_q};
  assign minor_step = (err_add > {2'b00, major_q});
  assign err_d      = minor_step ? (err_add - {2'b00, major_q}) : err_add;

  assign delta_x = {{(CoordBits - DIR_W){dir_x_q[DIR_W-1]}}, dir_x_q};
  assign delta_y = {{(CoordBits - DIR_W){dir_y_q[DIR_W-1]}}, dir_y_q};

  assign step_x_d = (x_major_q || minor_step) ? cur_x_q + delta_x : cur_x_q;
  assign step_y_d = (!x_major_q || minor_step) ? cur_y_q + delta_y : cur_y_q;

  assign interior = (step_q < major_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      step_q      <= '0;
      dir_x_q     <= DIR_ZERO;
      dir_y_q     <= DIR_ZERO;
      x_major_q   <= 1'b0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
      pix_x_q     <= '0;
      pix_y_q     <= '0;
      pix_color_q <= '0;
      pix_last_q  <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q <= (ctrl_i.mode == MODE_START) || (state_q == ST_DRAW);
        case (ctrl_i.mode)
          MODE_START: begin
            state_q     <= ST_DRAW;
            cur_x_q     <= start_x_i;
            cur_y_q     <= start_y_i;
            err_q       <= {3'b000, major_i[CoordBits-1:1]};
            major_q     <= major_i;
            minor_q     <= minor_i;
            step_q      <= CoordBits'(1);
            dir_x_q     <= ctrl_i.dir_x;
            dir_y_q     <= ctrl_i.dir_y;
            x_major_q   <= ctrl_i.x_major;
            tgt_x_q     <= end_x_i;
            tgt_y_q     <= end_y_i;
            color_q     <= color_i;
            pix_x_q     <= start_x_i;
            pix_y_q     <= start_y_i;
            pix_color_q <= color_i;
            pix_last_q  <= 1'b0;
          end
          MODE_ADVANCE: begin
            if (state_q == ST_DRAW) begin
              pix_color_q <= color_q;
              if (interior) begin
                err_q      <= err_d;
                cur_x_q    <= step_x_d;
                cur_y_q    <= step_y_d;
                step_q     <= step_q + 1'b1;
                pix_x_q    <= step_x_d;
                pix_y_q    <= step_y_d;
                pix_last_q <= 1'b0;
              end else begin
                state_q    <= ST_IDLE;
                cur_x_q    <= tgt_x_q;
                cur_y_q    <= tgt_y_q;
                pix_x_q    <= tgt_x_q;
                pix_y_q    <= tgt_y_q;
                pix_last_q <= 1'b1;
              end
            end
          end
          default: begin
            state_q <= state_q;
          end
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_pixel_o  = pix_last_q;

  assign status_o.busy  = (state_q == ST_DRAW);
  assign status_o.pop   = pop;
  assign status_o.start = (ctrl_i.mode == MODE_START);

endmodule

@@ design/line_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line stepper emitting one pixel per start item or advance item during a line.
// ----------------------------------------------------------------------------
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, mode, endpoints,   | input
//           | line_color                                |
//   out     | out_valid_o/out_ready_i, pixel_x/y,       | output
//           | pixel_color, last_pixel                   |
//
// One item per cycle sustained while the output is not stalled; an accepted
// item is written to the queue, then popped into the stepper output register.
// The stepper does one error add, compare and subtract per cycle.
// Reset clears the queue, the line state and the output valid.
// A stalled output holds the stepper; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_pixel_generator #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic signed [COORD_BITS-1:0]     start_x_i,
  input  logic signed [COORD_BITS-1:0]     start_y_i,
  input  logic signed [COORD_BITS-1:0]     end_x_i,
  input  logic signed [COORD_BITS-1:0]     end_y_i,
  input  logic [lpg_pkg::COLOR_W-1:0]      line_color_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COORD_BITS-1:0]     pixel_x_o,
  output logic signed [COORD_BITS-1:0]     pixel_y_o,
  output logic [lpg_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_pixel_o
);
  import lpg_pkg::*;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CmdW = $bits(lpg_ctrl_t) + 6 * COORD_BITS + COLOR_W;

  logic                  push;
  logic                  fifo_full;
  lpg_ctrl_t             front_ctrl;
  logic [COORD_BITS-1:0] front_major, front_minor;
  logic [CmdW-1:0]       wr_cmd, rd_cmd;
  logic                  cmd_valid;
  logic                  cmd_pop;

  lpg_ctrl_t             q_ctrl;
  logic [COORD_BITS-1:0] q_sx, q_sy, q_ex, q_ey, q_major, q_minor;
  logic [COLOR_W-1:0]    q_color;
  lpg_status_t           back_status;

  logic                  start_pop;
  logic                  line_busy;
  logic                  last_out;

  lpg_front #(
    .CoordBits (COORD_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .ctrl_o      (front_ctrl),
    .major_o     (front_major),
    .minor_o     (front_minor)
  );

  assign wr_cmd = {front_ctrl, start_x_i, start_y_i, end_x_i, end_y_i,
                   front_major, front_minor, line_color_i};

  lpg_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_cmd),
    .full_o    (fifo_full),
    .pop_i     (cmd_pop),
    .valid_o   (cmd_valid),
    .rd_data_o (rd_cmd)
  );

  assign {q_ctrl, q_sx, q_sy, q_ex, q_ey, q_major, q_minor, q_color} = rd_cmd;

  lpg_back #(
    .CoordBits (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .ctrl_i        (q_ctrl),
    .start_x_i     (q_sx),
    .start_y_i     (q_sy),
    .end_x_i       (q_ex),
    .end_y_i       (q_ey),
    .major_i       (q_major),
    .minor_i       (q_minor),
    .color_i       (q_color),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o),
    .status_o      (back_status)
  );

  assign start_pop = back_status.pop && back_status.start;
  assign line_busy = back_status.busy;
  assign last_out  = out_valid_o && last_pixel_o;

  `ASSERT_NEXT(a_start_sets_busy, clk_i, rst_ni, start_pop, line_busy, "start left line idle")
  `ASSERT_IMPL(a_last_at_idle, clk_i, rst_ni, $fell(line_busy), last_out, "no last pixel at end")
  `ASSERT_IMPL(a_out_from_pop, clk_i, rst_ni, $rose(out_valid_o), $past(cmd_pop), "no pop for result")

endmodule

@@ tb/sv/line_pixel_generator_tb.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator_tb
// Drives start and advance items into the line stepper and checks every
// emitted pixel against a cycle-free Bresenham tracker kept in a small
// scoreboard. A directed opening covers the coordinate extremes, restarts,
// single-point lines, unit lines and steep, flat and negative slopes;
// random lines follow, mostly short, some long, a few truncated by a
// restart, under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module line_pixel_generator_tb;
  import lpg_pkg::*;

  localparam int CW          = 12;
  localparam int ITEM_TARGET = 1500;
  localparam int LIMIT_TIME  = 12_000_000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [COLOR_W-1:0]   color;
    logic                 last;
  } pixel_t;

  class pixel_checker;
    pixel_t               pending_pixels[$];
    int                   errors;
    logic signed [CW-1:0] cur_x, cur_y, tgt_x, tgt_y;
    logic [CW+1:0]        err_acc;
    logic [CW-1:0]        major_len, minor_len, step_idx;
    int                   dir_x, dir_y;
    bit                   x_major, busy;
    logic [COLOR_W-1:0]   color;

    function void take_item(lpg_mode_e mode, logic signed [CW-1:0] sx,
                            logic signed [CW-1:0] sy, logic signed [CW-1:0] ex,
                            logic signed [CW-1:0] ey, logic [COLOR_W-1:0] col);
      int     dx, dy, ax, ay;
      pixel_t px;
      if (mode == MODE_START) begin
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        dir_x = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
        dir_y = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
        cur_x = sx;
        cur_y = sy;
        tgt_x = ex;
        tgt_y = ey;
        color = col;
        x_major = ax >= ay;
        major_len = CW'(x_major ? ax : ay);
        minor_len = CW'(x_major ? ay : ax);
        err_acc = (CW + 2)'(major_len >> 1);
        step_idx = CW'(1);
        busy = 1'b1;
        px.last = 1'b0;
      end else if (!busy) begin
        return;
      end else if (step_idx < major_len) begin
        err_acc = err_acc + (CW + 2)'(minor_len);
        if (x_major) cur_x = CW'(cur_x + dir_x);
        else cur_y = CW'(cur_y + dir_y);
        if (err_acc > (CW + 2)'(major_len)) begin
          err_acc = err_acc - (CW + 2)'(major_len);
          if (x_major) cur_y = CW'(cur_y + dir_y);
          else cur_x = CW'(cur_x + dir_x);
        end
        step_idx = CW'(step_idx + 1);
        px.last = 1'b0;
      end else begin
        busy = 1'b0;
        cur_x = tgt_x;
        cur_y = tgt_y;
        px.last = 1'b1;
      end
      px.x = cur_x;
      px.y = cur_y;
      px.color = color;
      pending_pixels.push_back(px);
    endfunction

    function void check_pixel(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic [COLOR_W-1:0] col, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
                 $time, x, y, col, last);
        return;
      end
      want = pending_pixels.pop_front();
      if (x !== want.x) begin
        errors++;
        $display("%0t: pixel_x expected %0d got %0d", $time, want.x, x);
      end
      if (y !== want.y) begin
        errors++;
        $display("%0t: pixel_y expected %0d got %0d", $time, want.y, y);
      end
      if (col !== want.color) begin
        errors++;
        $display("%0t: pixel_color expected %h got %h", $time, want.color, col);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_pixel expected %b got %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i       = 1'b0;
  logic signed [CW-1:0] start_x_i    = '0;
  logic signed [CW-1:0] start_y_i    = '0;
  logic signed [CW-1:0] end_x_i      = '0;
  logic signed [CW-1:0] end_y_i      = '0;
  logic [COLOR_W-1:0]   line_color_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic signed [CW-1:0] pixel_x_o;
  logic signed [CW-1:0] pixel_y_o;
  logic [COLOR_W-1:0]   pixel_color_o;
  logic                 last_pixel_o;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int line_items = 0;

  pixel_checker sb = new;

  line_pixel_generator #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_TIME);
    $display("line_pixel_generator test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.take_item(lpg_mode_e'(mode_i), start_x_i, start_y_i, end_x_i, end_y_i,
                     line_color_i);
      if (out_valid_o && out_ready_i)
        sb.check_pixel(pixel_x_o, pixel_y_o, pixel_color_o, last_pixel_o);
    end
  end

  task automatic send_item(input lpg_mode_e mode, input logic [CW-1:0] sx,
                           input logic [CW-1:0] sy, input logic [CW-1:0] ex,
                           input logic [CW-1:0] ey, input logic [COLOR_W-1:0] col);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    start_x_i    <= sx;
    start_y_i    <= sy;
    end_x_i      <= ex;
    end_y_i      <= ey;
    line_color_i <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_advance();
    send_item(MODE_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
              COLOR_W'($urandom));
  endtask

  task automatic random_line();
    int sel, span, sx, sy, ex, ey, dx, dy, ax, ay, steps;
    sel = $urandom_range(99);
    sx = int'($urandom_range(4095)) - 2048;
    sy = int'($urandom_range(4095)) - 2048;
    if (sel < 2) begin
      ex = int'($urandom_range(4095)) - 2048;
      ey = int'($urandom_range(4095)) - 2048;
    end else begin
      span = sel < 88 ? $urandom_range(12) : $urandom_range(300, 13);
      dx = int'($urandom_range(2 * span)) - span;
      dy = int'($urandom_range(2 * span)) - span;
      ex = (sx + dx > 2047 || sx + dx < -2048) ? sx - dx : sx + dx;
      ey = (sy + dy > 2047 || sy + dy < -2048) ? sy - dy : sy + dy;
    end
    ax = ex > sx ? ex - sx : sx - ex;
    ay = ey > sy ? ey - sy : sy - ey;
    steps = ax > ay ? ax : ay;
    if (steps == 0) steps = 1;
    // cut the line short now and then so the next start lands mid-line
    if ($urandom_range(99) < 12) steps = $urandom_range(steps - 1);
    if (steps > ITEM_TARGET / 4) steps = ITEM_TARGET / 4;
    send_item(MODE_START, CW'(sx), CW'(sy), CW'(ex), CW'(ey), COLOR_W'($urandom));
    repeat (steps) send_advance();
    line_items += 1 + steps;
    if ($urandom_range(99) < 8) send_advance();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_advance();
    send_item(MODE_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 16'hFFFF);
    repeat (3) send_advance();
    send_item(MODE_START, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047, 16'h0000);
    repeat (2) send_advance();
    send_item(MODE_START, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 16'hA5A5);
    repeat (2) send_advance();
    send_item(MODE_START, -12'sd1, 12'sd0, 12'sd0, 12'sd1, 16'h1234);
    repeat (2) send_advance();
    send_item(MODE_START, 12'sd0, 12'sd0, 12'sd1, -12'sd5, 16'h5A5A);
    repeat (5) send_advance();
    send_item(MODE_START, 12'sd3, 12'sd2, 12'sd0, 12'sd2, 16'h8001);
    repeat (3) send_advance();

    while (line_items < ITEM_TARGET) begin
      case (line_items * 4 / ITEM_TARGET)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct  = 11;
          stall_pct = 11;
        end
      endcase
      random_line();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("line_pixel_generator test passed");
    end else begin
      $display("line_pixel_generator test failed");
    end
    $finish;
  end

endmodule
